[hw/rtl/aosc_pkg.sv]
// ----------------------------------------------------------------------------
// aosc_pkg
// Shared widths, defaults and register map for the AND/OR subset convolution
// unit.
// ----------------------------------------------------------------------------
package aosc_pkg;

  // Default log2 of the largest vector length.
  localparam int unsigned MaxLogSizeDef = 6;

  // Fixed word widths.
  localparam int unsigned CoefW  = 32;
  localparam int unsigned DataW  = 64;
  localparam int unsigned IndexW = 6;

  // Configuration port.
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register index, taken from paddr bit 2.
  typedef enum logic {
    REG_OR_MODE = 1'b0
  } reg_idx_e;

endpackage

[hw/rtl/and_or_subset_convolution_unit.sv]
// ----------------------------------------------------------------------------
// and_or_subset_convolution_unit
// AND / OR subset convolution of two integer vectors via in-place butterfly
// transforms held in two synchronous memories.
// ----------------------------------------------------------------------------
// A run loads coefficient pairs at one word per cycle until the word marked
// last_in_i. With s pairs stored and n the next power of two at or above s,
// the block then zero-pads the entries s..n-1, runs the forward butterfly on
// both memories, multiplies pointwise with one shared 32x32 multiplier, runs
// the inverse butterfly on the first memory and emits the n results in index
// order. The single write port of each memory makes each butterfly write its
// low and high results in separate states, and the shared multiplier forms
// each product from three partial products. No input word is taken while a
// run is being computed; the next run may start loading while the final
// result still waits at the output. Arithmetic wraps modulo 2^64.
// ----------------------------------------------------------------------------
module and_or_subset_convolution_unit
  import aosc_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = MaxLogSizeDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input words
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoefW-1:0]  a_coef_i,
  input  logic signed [CoefW-1:0]  b_coef_i,
  input  logic                     last_in_i,
  // Result words
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DataW-1:0]  result_coef_o,
  output logic        [IndexW-1:0] result_index_o,
  output logic                     last_out_o,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic        [PaddrW-1:0] paddr,
  input  logic        [PdataW-1:0] pwdata,
  output logic        [PdataW-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned AddrW = MAX_LOG_SIZE;
  localparam int unsigned Cap   = 1 << MAX_LOG_SIZE;
  localparam int unsigned CntW  = MAX_LOG_SIZE + 1;
  localparam int unsigned LvlW  = $clog2(MAX_LOG_SIZE + 1);
  localparam int unsigned HalfW = DataW / 2;

  typedef enum logic [11:0] {
    S_LOAD = 12'b0000_0000_0001,
    S_PAD  = 12'b0000_0000_0010,
    S_BRD  = 12'b0000_0000_0100,
    S_BWLO = 12'b0000_0000_1000,
    S_BWHI = 12'b0000_0001_0000,
    S_MRD  = 12'b0000_0010_0000,
    S_MP0  = 12'b0000_0100_0000,
    S_MP1  = 12'b0000_1000_0000,
    S_MP2  = 12'b0001_0000_0000,
    S_MWR  = 12'b0010_0000_0000,
    S_ORD  = 12'b0100_0000_0000,
    S_OLD  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Control registers
  logic              or_mode_q, or_mode_d;
  logic [CntW-1:0]   load_count_q, load_count_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [LvlW-1:0]   log_n_q, log_n_d;
  logic [AddrW-1:0]  flip_q, flip_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [AddrW-1:0]  pair_q, pair_d;
  logic [LvlW-1:0]   lvl_q, lvl_d;
  logic              inv_q, inv_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers
  logic [DataW-1:0]  out_coef_q, out_coef_d;
  logic [AddrW-1:0]  out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;
  logic [DataW-1:0]  acc_q, acc_d;
  logic [DataW-1:0]  mul_q;

  // Memories and their ports
  logic [DataW-1:0]  mem_a [Cap];
  logic [DataW-1:0]  mem_b [Cap];
  logic              a_we, b_we;
  logic [AddrW-1:0]  a_waddr, b_waddr;
  logic [DataW-1:0]  a_wdata, b_wdata;
  logic              rd_en;
  logic [AddrW-1:0]  rd_lo_addr, rd_hi_addr;
  logic [DataW-1:0]  a_lo_q, a_hi_q, b_lo_q, b_hi_q;

  // Datapath helpers
  logic              in_acc, cfg_wr, full, out_load, lvl_done, pair_done, idx_done;
  logic [CntW-1:0]   s_new, pow_k;
  logic [LvlW-1:0]   log_new;
  logic [AddrW-1:0]  len_bit, len_mask, lo_log, lo_phys, hi_phys;
  logic [HalfW-1:0]  mul_x, mul_y;
  logic [DataW-1:0]  mul_p, mul_sum;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    or_mode_d = or_mode_q;
    if (cfg_wr && (reg_idx_e'(paddr[2]) == REG_OR_MODE)) begin
      or_mode_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx_e'(paddr[2]) == REG_OR_MODE) begin
      prdata = PdataW'(or_mode_q);
    end
  end

  // --------------------------------------------------------------------------
  // Address generation
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_LOAD);
  assign in_acc     = in_valid_i & in_ready_o;
  assign full       = (load_count_q == CntW'(Cap));

  // During the butterflies the logical vector index l lives at memory address
  // l ^ flip, so the OR mode reversal costs nothing beyond an XOR on those addresses.
  assign len_bit  = AddrW'(1) << lvl_q;
  assign len_mask = len_bit - AddrW'(1);
  assign lo_log   = AddrW'((pair_q & ~len_mask) << 1) | (pair_q & len_mask);
  assign lo_phys  = lo_log ^ flip_q;
  assign hi_phys  = (lo_log | len_bit) ^ flip_q;

  assign pair_done = ((CntW'(pair_q) + CntW'(1)) == (n_q >> 1));
  assign lvl_done  = ((CntW'(lvl_q) + CntW'(1)) == CntW'(log_n_q));
  assign idx_done  = ((idx_q + CntW'(1)) == n_q);
  assign out_load  = (state_q == S_OLD) && (!out_valid_q || out_ready_i);

  // Stored length and its power-of-two ceiling at the last word.
  always_comb begin
    s_new   = full ? load_count_q : (load_count_q + CntW'(1));
    log_new = LvlW'(MAX_LOG_SIZE);
    pow_k   = '0;
    for (int k = MAX_LOG_SIZE; k >= 0; k--) begin
      pow_k = CntW'(1) << k;
      if (pow_k >= s_new) begin
        log_new = LvlW'(k);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared 32x32 multiplier: three partial products give the low 64 bits.
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (state_q)
      S_MP0: begin
        mul_x = a_lo_q[HalfW-1:0];
        mul_y = b_lo_q[HalfW-1:0];
      end
      S_MP1: begin
        mul_x = a_lo_q[HalfW-1:0];
        mul_y = b_lo_q[DataW-1:HalfW];
      end
      default: begin
        mul_x = a_lo_q[DataW-1:HalfW];
        mul_y = b_lo_q[HalfW-1:0];
      end
    endcase
  end

  assign mul_p   = DataW'(mul_x) * DataW'(mul_y);
  assign mul_sum = acc_q + {mul_q[HalfW-1:0], {HalfW{1'b0}}};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    load_count_d = load_count_q;
    n_d          = n_q;
    log_n_d      = log_n_q;
    flip_d       = flip_q;
    idx_d        = idx_q;
    pair_d       = pair_q;
    lvl_d        = lvl_q;
    inv_d        = inv_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q;
    out_coef_d   = out_coef_q;
    out_idx_d    = out_idx_q;
    out_last_d   = out_last_q;
    a_we         = 1'b0;
    b_we         = 1'b0;
    a_waddr      = idx_q[AddrW-1:0];
    b_waddr      = idx_q[AddrW-1:0];
    a_wdata      = '0;
    b_wdata      = '0;
    rd_en        = 1'b0;
    rd_lo_addr   = idx_q[AddrW-1:0];
    rd_hi_addr   = idx_q[AddrW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          a_waddr = load_count_q[AddrW-1:0];
          b_waddr = load_count_q[AddrW-1:0];
          a_wdata = {{(DataW-CoefW){a_coef_i[CoefW-1]}}, a_coef_i};
          b_wdata = {{(DataW-CoefW){b_coef_i[CoefW-1]}}, b_coef_i};
          a_we    = !full;
          b_we    = !full;
          load_count_d = s_new;
          if (last_in_i) begin
            load_count_d = '0;
            log_n_d      = log_new;
            n_d          = CntW'(1) << log_new;
            flip_d       = or_mode_q ? AddrW'((CntW'(1) << log_new) - CntW'(1)) : '0;
            idx_d        = s_new;
            state_d      = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (idx_q < n_q) begin
          a_we  = 1'b1;
          b_we  = 1'b1;
          idx_d = idx_q + CntW'(1);
        end else begin
          pair_d = '0;
          lvl_d  = '0;
          inv_d  = 1'b0;
          idx_d  = '0;
          state_d = (log_n_q == '0) ? S_MRD : S_BRD;
        end
      end
      S_BRD: begin
        rd_en      = 1'b1;
        rd_lo_addr = lo_phys;
        rd_hi_addr = hi_phys;
        state_d    = S_BWLO;
      end
      S_BWLO: begin
        // Forward: lo takes v. Inverse: lo takes v - u.
        a_we    = 1'b1;
        a_waddr = lo_phys;
        a_wdata = inv_q ? (a_hi_q - a_lo_q) : a_hi_q;
        b_we    = !inv_q;
        b_waddr = lo_phys;
        b_wdata = b_hi_q;
        state_d = S_BWHI;
      end
      S_BWHI: begin
        // Forward: hi takes u + v. Inverse: hi takes u.
        a_we    = 1'b1;
        a_waddr = hi_phys;
        a_wdata = inv_q ? a_lo_q : (a_lo_q + a_hi_q);
        b_we    = !inv_q;
        b_waddr = hi_phys;
        b_wdata = b_lo_q + b_hi_q;
        state_d = S_BRD;
        if (pair_done) begin
          pair_d = '0;
          if (lvl_done) begin
            lvl_d   = '0;
            idx_d   = '0;
            state_d = inv_q ? S_ORD : S_MRD;
          end else begin
            lvl_d = lvl_q + LvlW'(1);
          end
        end else begin
          pair_d = pair_q + AddrW'(1);
        end
      end
      S_MRD: begin
        rd_en   = 1'b1;
        state_d = S_MP0;
      end
      S_MP0: begin
        state_d = S_MP1;
      end
      S_MP1: begin
        acc_d   = mul_q;
        state_d = S_MP2;
      end
      S_MP2: begin
        acc_d   = mul_sum;
        state_d = S_MWR;
      end
      S_MWR: begin
        a_we    = 1'b1;
        a_wdata = mul_sum;
        if (idx_done) begin
          inv_d   = 1'b1;
          pair_d  = '0;
          lvl_d   = '0;
          idx_d   = '0;
          state_d = (log_n_q == '0) ? S_ORD : S_BRD;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_MRD;
        end
      end
      S_ORD: begin
        rd_en   = 1'b1;
        state_d = S_OLD;
      end
      S_OLD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_coef_d  = a_lo_q;
          out_idx_d   = idx_q[AddrW-1:0];
          out_last_d  = idx_done;
          if (idx_done) begin
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      or_mode_q    <= 1'b0;
      load_count_q <= '0;
      n_q          <= '0;
      log_n_q      <= '0;
      flip_q       <= '0;
      idx_q        <= '0;
      pair_q       <= '0;
      lvl_q        <= '0;
      inv_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      or_mode_q    <= or_mode_d;
      load_count_q <= load_count_d;
      n_q          <= n_d;
      log_n_q      <= log_n_d;
      flip_q       <= flip_d;
      idx_q        <= idx_d;
      pair_q       <= pair_d;
      lvl_q        <= lvl_d;
      inv_q        <= inv_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_coef_q <= out_coef_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    acc_q      <= acc_d;
    mul_q      <= mul_p;
  end

  // Coefficient memories: one write port, two read ports, registered reads.
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[a_waddr] <= a_wdata;
    end
    if (rd_en) begin
      a_lo_q <= mem_a[rd_lo_addr];
      a_hi_q <= mem_a[rd_hi_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      mem_b[b_waddr] <= b_wdata;
    end
    if (rd_en) begin
      b_lo_q <= mem_b[rd_lo_addr];
      b_hi_q <= mem_b[rd_hi_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_coef_o  = out_coef_q;
  assign result_index_o = IndexW'(out_idx_q);
  assign last_out_o     = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_count_q <= CntW'(Cap))
    else $error("load count beyond memory depth");

  a_pair_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BWLO || state_q == S_BWHI) |-> (lo_phys != hi_phys))
    else $error("butterfly operands share one address");

  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BRD) |-> ((CntW'(pair_q) < (n_q >> 1)) && (CntW'(lvl_q) < CntW'(log_n_q))))
    else $error("butterfly counters out of range");

  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && idx_q != '0) |-> (out_idx_q == AddrW'(idx_q - CntW'(1))))
    else $error("result words out of index order");

endmodule

[tb/and_or_subset_convolution_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// and_or_subset_convolution_unit_test
// Self-checking bench for the AND/OR subset convolution unit. Coefficient
// pairs are sent in runs closed by last_in_i. A predictor in the bench works
// out the zeta transform, pointwise product and inverse transform for every
// run, and each result word is compared with the oldest predicted one. Both
// handshakes are throttled at random, and the mode register is changed
// between runs.
// ----------------------------------------------------------------------------
module and_or_subset_convolution_unit_test;
  import aosc_pkg::*;

  localparam int unsigned Depth         = 1 << MaxLogSizeDef;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned SettleCycles  = 40;
  localparam logic        ModeAnd       = 1'b0;
  localparam logic        ModeOr        = 1'b1;
  localparam logic [PaddrW-1:0] OrModeAddr = {REG_OR_MODE, 2'b00};
  // Register index 1 does not exist, so a write there must change nothing.
  localparam logic [PaddrW-1:0] SpareAddr  = 3'b100;

  typedef struct {
    logic [CoefW-1:0] a;
    logic [CoefW-1:0] b;
    logic             last;
  } coef_pair_t;

  typedef struct {
    logic [DataW-1:0]  coef;
    logic [IndexW-1:0] index;
    logic              last;
  } conv_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CoefW-1:0] a_coef_i = '0;
  logic signed [CoefW-1:0] b_coef_i = '0;
  logic last_in_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DataW-1:0] result_coef_o;
  logic [IndexW-1:0] result_index_o;
  logic last_out_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic pready;

  coef_pair_t coef_pairs_to_send[$];
  conv_word_t conv_results_due[$];
  coef_pair_t next_pair;
  conv_word_t due_word;

  // Bench copy of the block state.
  logic [DataW-1:0] a_held [Depth];
  logic [DataW-1:0] b_held [Depth];
  int unsigned pair_count = 0;
  logic conv_mode = ModeAnd;

  bit no_gaps = 1'b0;
  int mismatches = 0;
  int unsigned quiet_cycles = 0;

  and_or_subset_convolution_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .a_coef_i      (a_coef_i),
    .b_coef_i      (b_coef_i),
    .last_in_i     (last_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_coef_o (result_coef_o),
    .result_index_o(result_index_o),
    .last_out_o    (last_out_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stores one pair and, on the closing word of a run, queues the n
  // convolution coefficients the block should emit.
  task automatic predict_convolution(input logic [CoefW-1:0] a, input logic [CoefW-1:0] b,
                                     input logic last);
    logic [DataW-1:0] za [Depth];
    logic [DataW-1:0] zb [Depth];
    logic [DataW-1:0] u, v, x, y;
    int unsigned n, flip, src, span, i, j;
    conv_word_t w;
    if (pair_count < Depth) begin
      a_held[pair_count] = {{(DataW-CoefW){a[CoefW-1]}}, a};
      b_held[pair_count] = {{(DataW-CoefW){b[CoefW-1]}}, b};
      pair_count++;
    end
    if (!last) return;
    n = 1;
    while (n < pair_count) n = n << 1;
    flip = (conv_mode == ModeOr) ? n - 1 : 0;
    for (i = 0; i < n; i++) begin
      src = i ^ flip;
      za[i] = (src < pair_count) ? a_held[src] : '0;
      zb[i] = (src < pair_count) ? b_held[src] : '0;
    end
    for (span = 1; 2 * span <= n; span = span << 1) begin
      for (i = 0; i < n; i += 2 * span) begin
        for (j = 0; j < span; j++) begin
          u = za[i+j];
          v = za[i+span+j];
          x = zb[i+j];
          y = zb[i+span+j];
          za[i+j] = v;
          za[i+span+j] = u + v;
          zb[i+j] = y;
          zb[i+span+j] = x + y;
        end
      end
    end
    for (i = 0; i < n; i++) za[i] = za[i] * zb[i];
    for (span = 1; 2 * span <= n; span = span << 1) begin
      for (i = 0; i < n; i += 2 * span) begin
        for (j = 0; j < span; j++) begin
          u = za[i+j];
          v = za[i+span+j];
          za[i+j] = v - u;
          za[i+span+j] = u;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      w.coef = za[i ^ flip];
      w.index = i[IndexW-1:0];
      w.last = (i == n - 1);
      conv_results_due.push_back(w);
    end
    pair_count = 0;
  endtask

  // Input word driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      a_coef_i <= '0;
      b_coef_i <= '0;
      last_in_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (coef_pairs_to_send.size() > 0 && (no_gaps || $urandom_range(99) >= 22)) begin
        next_pair = coef_pairs_to_send.pop_front();
        in_valid_i <= 1'b1;
        a_coef_i <= next_pair.a;
        b_coef_i <= next_pair.b;
        last_in_i <= next_pair.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_gaps || ($urandom_range(99) >= 22);
    end
  end

  // Monitor: predicts on accepted input words, checks accepted result words.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_convolution(a_coef_i, b_coef_i, last_in_i);
      if (out_valid_o && out_ready_i) begin
        if (conv_results_due.size() == 0) begin
          $error("unexpected result word: coef %h index %0d", result_coef_o, result_index_o);
          mismatches++;
        end else begin
          due_word = conv_results_due.pop_front();
          if (result_coef_o !== due_word.coef) begin
            $error("result_coef: expected %h, got %h", due_word.coef, result_coef_o);
            mismatches++;
          end
          if (result_index_o !== due_word.index) begin
            $error("result_index: expected %0d, got %0d", due_word.index, result_index_o);
            mismatches++;
          end
          if (last_out_o !== due_word.last) begin
            $error("last_out: expected %b, got %b", due_word.last, last_out_o);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [PaddrW-1:0] addr, input logic [PdataW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[PaddrW-1:2] == REG_OR_MODE) conv_mode = data[0];
  endtask

  task automatic push_pair(input logic [CoefW-1:0] a, input logic [CoefW-1:0] b,
                           input logic last);
    coef_pair_t p;
    p.a = a;
    p.b = b;
    p.last = last;
    coef_pairs_to_send.push_back(p);
  endtask

  function automatic logic [CoefW-1:0] random_coef();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4: return CoefW'($urandom_range(15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_run(input int unsigned pairs);
    for (int unsigned k = 0; k < pairs; k++) push_pair(random_coef(), random_coef(), k == pairs - 1);
  endtask

  // Returns once every word is sent and every predicted result has arrived.
  task automatic wait_drained();
    @(posedge clk_i);
    while (coef_pairs_to_send.size() != 0 || in_valid_i || conv_results_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_words, run_len, pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed runs in AND mode, straight out of reset.
    push_pair(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    push_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
    push_pair(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    push_pair(32'hffff_ffff, 32'h8000_0000, 1'b1);
    push_pair(32'd1, 32'd2, 1'b0);
    push_pair(32'd3, 32'd4, 1'b0);
    push_pair(32'd5, 32'd6, 1'b1);
    push_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    push_pair(32'h8000_0000, 32'hffff_ffff, 1'b0);
    push_pair(32'hffff_ffff, 32'h7fff_ffff, 1'b0);
    push_pair(32'h0000_0000, 32'h8000_0000, 1'b0);
    push_pair(32'h5555_aaaa, 32'haaaa_5555, 1'b1);
    wait_drained();

    write_reg(OrModeAddr, {$urandom} | 32'd1);
    push_pair(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    push_pair(32'd7, 32'hffff_fff9, 1'b0);
    push_pair(32'h7fff_ffff, 32'd3, 1'b0);
    push_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
    push_pair(32'd1, 32'd10, 1'b0);
    push_pair(32'd2, 32'd20, 1'b0);
    push_pair(32'd3, 32'd30, 1'b0);
    push_pair(32'd4, 32'd40, 1'b1);
    wait_drained();

    // A write to the missing register leaves OR mode in place.
    write_reg(SpareAddr, 32'h0);
    push_pair(32'hdead_beef, 32'h1234_5678, 1'b0);
    push_pair(32'hffff_ffff, 32'h7fff_ffff, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_reg(OrModeAddr, {$urandom} & ~32'd1);
        1: write_reg(OrModeAddr, {$urandom} | 32'd1);
        default: write_reg(OrModeAddr, $urandom);
      endcase
      no_gaps = (phase == 2);
      phase_words = 0;
      if (phase == 1) begin
        // More pairs than the stores hold; the extra ones are dropped.
        run_len = Depth + $urandom_range(1, 5);
        queue_random_run(run_len);
        phase_words += run_len;
      end
      if (phase == 3) begin
        queue_random_run(Depth / 4 + 1);
        phase_words += Depth / 4 + 1;
      end
      while (phase_words < 12) begin
        pick = $urandom_range(99);
        if (pick < 75) run_len = $urandom_range(1, 8);
        else if (pick < 95) run_len = $urandom_range(9, 20);
        else run_len = $urandom_range(21, 40);
        queue_random_run(run_len);
        phase_words += run_len;
      end
      wait_drained();
    end
    no_gaps = 1'b0;

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
